[src/rbd4_pkg.sv]
// Package for the RGB box downscale by four block.
// Holds field widths, register and row phase codes and the rounding average.
// No dependencies.
package rbd4_pkg;

    localparam int PIX_W    = 8;
    localparam int CHANNELS = 3;
    localparam int RGB_W    = PIX_W * CHANNELS;
    localparam int SUM_W    = 10;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int ROW_W    = 12;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] PH_ROW0 = 2'd0;
    localparam logic [1:0] PH_ROW1 = 2'd1;
    localparam logic [1:0] PH_ROW2 = 2'd2;
    localparam logic [1:0] PH_ROW3 = 2'd3;

    localparam logic [1:0] COL_FIRST = 2'd0;
    localparam logic [1:0] COL_LAST  = 2'd3;

    localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = 12'd4;
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = 13'd4;
    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

    function automatic logic [PIX_W-1:0] avg8(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
        return s[PIX_W:1];
    endfunction

endpackage

[src/rbd4_if.sv]
// Stream interfaces for the input pixels and the downscaled pixels.
// Depends on rbd4_pkg for the channel width.
interface rbd4_in_if import rbd4_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rbd4_out_if import rbd4_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, red_out, green_out, blue_out, row_end, frame_end,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, row_end, frame_end,
                  output ready);
endinterface

[src/rgb_box_downscale_by_four_top.sv]
// RGB box downscale by four: one output pixel for each 4 by 4 block of a raster frame.
// Depends on rbd4_pkg and the stream interfaces in rbd4_if.sv.
//
// The block takes one pixel item per clock and keeps that rate for as long as the output
// side takes its items; an item is held for two pipeline registers (memory read, then
// combine and write back), so a result reaches the output register after the fourth
// pixel of a block on its last row is accepted. The rate is set by the two line memories
// of MAX_WIDTH entries of 24 bits, each read once and written once per cycle. A stalled
// output holds one item in the pipeline before the input stops. The line memories need
// no clearing after reset. Writing either register restarts the frame.
module rgb_box_downscale_by_four_top import rbd4_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    rbd4_in_if.sink            i_pix,
    rbd4_out_if.source         o_pix
);

    localparam int WCAP      = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
    localparam int COL_W     = $clog2(WCAP);
    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int RST_WIDE  = (WCAP < 2048) ? WCAP : 2048;
    localparam logic [WIDTH_W-1:0] WCAP_V = WIDTH_W'(WCAP);

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [COL_W-1:0]    r_wide_m1;
    logic [COL_W-1:0]    r_last_fc;
    logic [ROW_W-1:0]    r_tall_m1;
    logic [ROW_W-1:0]    r_last_fr;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [RGB_W-1:0] pair_mem  [MAX_WIDTH];
    logic [RGB_W-1:0] third_mem [MAX_WIDTH];
    logic [RGB_W-1:0] r_pair_rd;
    logic [RGB_W-1:0] r_third_rd;

    logic             r_s1_valid;
    logic             r_s1_active;
    logic [1:0]       r_s1_phase;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_row_end;
    logic             r_s1_frame_end;
    logic [RGB_W-1:0] r_s1_pix;

    logic [CHANNELS*SUM_W-1:0] r_sums;
    logic [CHANNELS*SUM_W-1:0] n_sums;
    logic [RGB_W-1:0]          pair_avg;
    logic [RGB_W-1:0]          box_out;

    logic             r_o_valid;
    logic [RGB_W-1:0] r_o_rgb;
    logic             r_o_row_end;
    logic             r_o_frame_end;

    logic                cfg_wr;
    logic [WIDTH_W-1:0]  wide_c;
    logic [HEIGHT_W-1:0] tall_c;
    logic                in_acc;
    logic                s1_last;
    logic                s1_emit;
    logic                s1_adv;
    logic                pair_we;
    logic                third_we;
    logic [RGB_W-1:0]    pair_wd;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ?
                    PDATA_W'(r_image_height) : PDATA_W'(r_image_width);

    always_comb begin
        if (pwdata[WIDTH_W-1:0] < MIN_WIDTH) begin
            wide_c = MIN_WIDTH;
        end else if (pwdata[WIDTH_W-1:0] > WCAP_V) begin
            wide_c = WCAP_V;
        end else begin
            wide_c = pwdata[WIDTH_W-1:0];
        end
        if (pwdata[HEIGHT_W-1:0] < MIN_HEIGHT) begin
            tall_c = MIN_HEIGHT;
        end else if (pwdata[HEIGHT_W-1:0] > HEIGHT_LIMIT) begin
            tall_c = HEIGHT_LIMIT;
        end else begin
            tall_c = pwdata[HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 12'd2048;
            r_image_height <= 13'd4096;
            r_wide_m1      <= COL_W'(RST_WIDE - 1);
            r_last_fc      <= COL_W'((RST_WIDE / 4) * 4 - 1);
            r_tall_m1      <= 12'd4095;
            r_last_fr      <= 12'd4095;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_IMAGE_WIDTH) begin
                r_image_width <= pwdata[WIDTH_W-1:0];
                r_wide_m1     <= COL_W'(wide_c - 12'd1);
                r_last_fc     <= COL_W'((wide_c & ~12'd3) - 12'd1);
            end else begin
                r_image_height <= pwdata[HEIGHT_W-1:0];
                r_tall_m1      <= ROW_W'(tall_c - 13'd1);
                r_last_fr      <= ROW_W'((tall_c & ~13'd3) - 13'd1);
            end
        end
    end

    // Handshakes and pipeline control.
    assign s1_last     = r_s1_active && (r_s1_phase == PH_ROW3);
    assign s1_emit     = s1_last && (r_s1_col[1:0] == COL_LAST);
    assign s1_adv      = r_s1_valid && (!s1_emit || !r_o_valid || o_pix.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;

    // Position counters.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (r_col == r_wide_m1) begin
            n_col = '0;
            n_row = (r_row == r_tall_m1) ? '0 : r_row + 12'd1;
        end else begin
            n_col = r_col + {{(COL_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage one: item registered while the line memories are read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_active    <= (r_col <= r_last_fc) && (r_row <= r_last_fr);
            r_s1_phase     <= r_row[1:0];
            r_s1_col       <= r_col;
            r_s1_row_end   <= (r_col == r_last_fc);
            r_s1_frame_end <= (r_col == r_last_fc) && (r_row == r_last_fr);
            r_s1_pix       <= {i_pix.blue_in, i_pix.green_in, i_pix.red_in};
        end
    end

    // Line memories. A column is revisited only a whole row later, so the write of one
    // item never meets the read of the next.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pair_rd  <= pair_mem[AW'(r_col)];
            r_third_rd <= third_mem[AW'(r_col)];
        end
    end

    assign pair_we  = s1_adv && r_s1_active &&
                      ((r_s1_phase == PH_ROW0) || (r_s1_phase == PH_ROW1));
    assign third_we = s1_adv && r_s1_active && (r_s1_phase == PH_ROW2);
    assign pair_wd  = (r_s1_phase == PH_ROW0) ? r_s1_pix : pair_avg;

    always_ff @(posedge i_clk) begin
        if (pair_we) begin
            pair_mem[AW'(r_s1_col)] <= pair_wd;
        end
        if (third_we) begin
            third_mem[AW'(r_s1_col)] <= r_s1_pix;
        end
    end

    // Stage two: vertical averages and horizontal sums.
    always_comb begin
        logic [PIX_W-1:0] p;
        logic [PIX_W-1:0] t;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] v;
        logic [SUM_W-1:0] base;
        logic [SUM_W-1:0] s;
        pair_avg = '0;
        box_out  = '0;
        n_sums   = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            p    = r_pair_rd[PIX_W*c +: PIX_W];
            t    = r_third_rd[PIX_W*c +: PIX_W];
            x    = r_s1_pix[PIX_W*c +: PIX_W];
            v    = avg8(p, avg8(t, x));
            base = (r_s1_col[1:0] == COL_FIRST) ? '0 : r_sums[SUM_W*c +: SUM_W];
            s    = base + SUM_W'(v);
            pair_avg[PIX_W*c +: PIX_W] = avg8(p, x);
            n_sums[SUM_W*c +: SUM_W]   = s;
            box_out[PIX_W*c +: PIX_W]  = s[SUM_W-1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (cfg_wr) begin
            r_sums <= '0;
        end else if (s1_adv && s1_last) begin
            r_sums <= s1_emit ? '0 : n_sums;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && s1_emit) begin
            r_o_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emit) begin
            r_o_rgb       <= box_out;
            r_o_row_end   <= r_s1_row_end;
            r_o_frame_end <= r_s1_frame_end;
        end
    end

    assign o_pix.valid     = r_o_valid;
    assign o_pix.red_out   = r_o_rgb[PIX_W-1:0];
    assign o_pix.green_out = r_o_rgb[2*PIX_W-1:PIX_W];
    assign o_pix.blue_out  = r_o_rgb[3*PIX_W-1:2*PIX_W];
    assign o_pix.row_end   = r_o_row_end;
    assign o_pix.frame_end = r_o_frame_end;

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_wide_m1)
        else $error("Column counter has run past the row width.");

    a_frame_end_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_frame_end) |-> r_o_row_end)
        else $error("Frame end flagged on an item that does not end its row.");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_s1_valid)
        else $error("Accepted item is missing from the first stage.");
`endif

endmodule
